### src/rcfd_pkg.sv
`default_nettype none

package rcfd_pkg;

  localparam int FRAME_LEN  = 18;
  localparam int COUNT_OVER = 19;
  localparam int COUNT_W    = 5;

  // Configuration register indexes
  localparam logic [1:0] CFG_STICK_MIN     = 2'd0;
  localparam logic [1:0] CFG_STICK_MAX     = 2'd1;
  localparam logic [1:0] CFG_CENTRE_OFFSET = 2'd2;
  localparam logic [1:0] CFG_DEAD_ZONE     = 2'd3;

  localparam logic [10:0] STICK_MIN_RST     = 11'd364;
  localparam logic [10:0] STICK_MAX_RST     = 11'd1684;
  localparam logic [10:0] CENTRE_OFFSET_RST = 11'd1024;
  localparam logic [11:0] DEAD_ZONE_RST     = 12'd10;

  localparam logic [10:0] STICK_MASK = 11'h7FF;

  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       burst_end;
  } in_word_t;

  typedef struct packed {
    logic signed [11:0] stick_right_h;
    logic signed [11:0] stick_right_v;
    logic signed [11:0] stick_left_h;
    logic signed [11:0] stick_left_v;
    logic [3:0]         switches;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
    logic signed [15:0] mouse_dz;
    logic [15:0]        mouse_buttons;
    logic [15:0]        key_bits;
    logic signed [15:0] wheel;
    logic               frame_status;
  } out_word_t;

  typedef struct packed {
    logic [10:0] stick_min;
    logic [10:0] stick_max;
    logic [10:0] centre_offset;
    logic [11:0] dead_zone;
  } cfg_t;

endpackage

`default_nettype wire

### src/rcfd_decode.sv
`default_nettype none

module rcfd_decode (
  input  wire rcfd_pkg::frame_t    frame,
  input  wire rcfd_pkg::cfg_t      cfg,
  output rcfd_pkg::out_word_t      result
);

  logic [3:0][10:0]         ch;
  logic [3:0]               ch_bad;
  logic [3:0][11:0]         stick;
  logic [15:0]              wheel_raw;
  logic [15:0]              wheel_diff;
  logic signed [16:0]       wheel_ext;
  logic [16:0]              wheel_mag;
  logic [16:0]              wheel_dz;
  logic [15:0]              wheel_out;

  function automatic logic [11:0] stick_value(input logic [10:0] raw,
                                              input logic [10:0] centre,
                                              input logic [11:0] dz);
    logic signed [11:0] v;
    logic [11:0]        mag;
    v   = $signed({1'b0, raw}) - $signed({1'b0, centre});
    mag = v[11] ? 12'(-v) : 12'(v);
    return (mag <= dz) ? 12'd0 : 12'(v);
  endfunction

  always_comb begin
    ch[0] = {frame[1][2:0], frame[0]};
    ch[1] = {frame[2][5:0], frame[1][7:3]};
    ch[2] = {frame[4][0], frame[3], frame[2][7:6]};
    ch[3] = {frame[5][3:0], frame[4][7:1]};
    for (int i = 0; i < 4; i++) begin
      ch_bad[i] = (ch[i] < cfg.stick_min) || (ch[i] > cfg.stick_max);
      stick[i]  = stick_value(ch[i], cfg.centre_offset, cfg.dead_zone);
    end
  end

  // The wheel difference wraps to 16 bits before the dead zone is applied.
  always_comb begin
    wheel_raw  = {frame[17], frame[16]};
    wheel_diff = wheel_raw - {5'd0, cfg.centre_offset};
    wheel_ext  = $signed({wheel_diff[15], wheel_diff});
    wheel_mag  = wheel_ext[16] ? 17'(-wheel_ext) : 17'(wheel_ext);
    wheel_dz   = ({5'd0, cfg.dead_zone} << 3) + ({5'd0, cfg.dead_zone} << 1);
    wheel_out  = (wheel_mag <= wheel_dz) ? 16'd0 : wheel_diff;
  end

  always_comb begin
    if (|ch_bad) begin
      result              = '0;
      result.frame_status = 1'b1;
    end else begin
      result.stick_right_h = stick[0];
      result.stick_right_v = stick[1];
      result.stick_left_h  = stick[2];
      result.stick_left_v  = stick[3];
      result.switches      = frame[5][7:4];
      result.mouse_dx      = {frame[7], frame[6]};
      result.mouse_dy      = {frame[9], frame[8]};
      result.mouse_dz      = {frame[11], frame[10]};
      result.mouse_buttons = {frame[13], frame[12]};
      result.key_bits      = {frame[15], frame[14]};
      result.wheel         = wheel_out;
      result.frame_status  = 1'b0;
    end
  end

endmodule

`default_nettype wire

### src/rc_receiver_frame_decoder.sv
// An 18-byte burst's last byte sets pend_r; out_data_r then takes the decoded word.
// Throughput: one byte per cycle; the shift line and the result register form two stages.
// Input stalls only while a decoded frame waits behind a stalled, full result register.
// Synchronous active-low reset clears the byte count, valid flags and configuration
// registers to their defaults; the frame shift line itself is not reset.
`default_nettype none

module rc_receiver_frame_decoder (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire rcfd_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire                      out_stall,
  output rcfd_pkg::out_word_t      out_data,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire [1:0]                cfg_index,
  input  wire [11:0]               cfg_data
);

  rcfd_pkg::frame_t                  frame_r;
  logic [rcfd_pkg::COUNT_W-1:0]      byte_count_r, byte_count_nxt, count_inc;
  logic                              pend_r, pend_nxt;
  logic                              out_valid_r, out_valid_nxt;
  rcfd_pkg::out_word_t               out_data_r;
  rcfd_pkg::out_word_t               decoded;
  rcfd_pkg::cfg_t                    cfg_r;
  logic                              in_acc, out_load, frame_done;

  assign cfg_ready = 1'b1;
  assign out_load  = pend_r && (!out_valid_r || !out_stall);
  // The shift line must hold while a finished frame cannot move on.
  assign in_stall  = pend_r && !out_load;
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    count_inc  = (byte_count_r < 5'(rcfd_pkg::COUNT_OVER)) ? byte_count_r + 5'd1
                                                           : byte_count_r;
    frame_done = in_data.burst_end && (count_inc == 5'(rcfd_pkg::FRAME_LEN));
    byte_count_nxt = byte_count_r;
    pend_nxt       = out_load ? 1'b0 : pend_r;
    if (in_acc) begin
      byte_count_nxt = in_data.burst_end ? '0 : count_inc;
      pend_nxt       = frame_done;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Oldest byte sits at index 0, so after exactly eighteen bytes it is frame byte 0.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < rcfd_pkg::FRAME_LEN - 1; i++) begin
        frame_r[i] <= frame_r[i+1];
      end
      frame_r[rcfd_pkg::FRAME_LEN-1] <= in_data.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stick_min     <= rcfd_pkg::STICK_MIN_RST;
      cfg_r.stick_max     <= rcfd_pkg::STICK_MAX_RST;
      cfg_r.centre_offset <= rcfd_pkg::CENTRE_OFFSET_RST;
      cfg_r.dead_zone     <= rcfd_pkg::DEAD_ZONE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rcfd_pkg::CFG_STICK_MIN:     cfg_r.stick_min     <= cfg_data[10:0];
        rcfd_pkg::CFG_STICK_MAX:     cfg_r.stick_max     <= cfg_data[10:0];
        rcfd_pkg::CFG_CENTRE_OFFSET: cfg_r.centre_offset <= cfg_data[10:0];
        rcfd_pkg::CFG_DEAD_ZONE:     cfg_r.dead_zone     <= cfg_data;
        default: ;
      endcase
    end
  end

  rcfd_decode u_decode (
    .frame  (frame_r),
    .cfg    (cfg_r),
    .result (decoded)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= 5'(rcfd_pkg::COUNT_OVER))
    else $error("byte count beyond saturation");

  a_burst_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.burst_end |=> byte_count_r == '0)
    else $error("byte count not cleared after burst end");

  a_frame_pends: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && frame_done |=> pend_r)
    else $error("complete frame not marked for decode");

  a_pend_holds: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && !out_load |=> pend_r && $stable(frame_r))
    else $error("waiting frame lost or overwritten");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.frame_status |-> out_data_r.wheel == '0 &&
      out_data_r.stick_right_h == '0 && out_data_r.key_bits == '0)
    else $error("rejected frame carries non-zero fields");

endmodule

`default_nettype wire
